// ===== sv/dbde_pkg.sv =====
// ----------------------------------------------------------------------------
// Dual button debounce events package
// Register indexes, reset values and the status record shared by the block.
// ----------------------------------------------------------------------------
package dbde_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int PERIOD_BITS    = 10;
   localparam int MS_BITS        = 16;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_TICK_PERIOD = 2'd0;
   localparam csr_index_type CSR_DEBOUNCE    = 2'd1;
   localparam csr_index_type CSR_SHORT_MAX   = 2'd2;
   localparam csr_index_type CSR_HOLD_BOTH   = 2'd3;

   localparam logic [PERIOD_BITS-1:0] TICK_PERIOD_RESET = 10'd10;
   localparam logic [MS_BITS-1:0]     DEBOUNCE_RESET    = 16'd50;
   localparam logic [MS_BITS-1:0]     SHORT_MAX_RESET   = 16'd1000;
   localparam logic [MS_BITS-1:0]     HOLD_BOTH_RESET   = 16'd3000;

   typedef struct packed {
      logic down;
      logic short_fire;
   } button_status_type;

endpackage

// ===== sv/dbde_button.sv =====
// ----------------------------------------------------------------------------
// Single button debouncer
// Tracks raw level changes, accepts a level after the debounce time, stamps
// presses and flags a short press on release.
// ----------------------------------------------------------------------------
module dbde_button
   import dbde_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   raw,
   input  logic [TIME_BITS-1:0]   now_ms,
   input  logic [MS_BITS-1:0]     debounce_ms,
   input  logic [MS_BITS-1:0]     short_max_ms,
   input  logic                   cancel,
   output button_status_type      status,
   output logic [TIME_BITS-1:0]   stamp_next
);

   logic                 down_ff, down_in;
   logic                 prev_raw_ff;
   logic [TIME_BITS-1:0] change_ff, change_in;
   logic [TIME_BITS-1:0] stamp_ff;
   logic                 waiting_ff, waiting_in;
   logic                 waiting_mid;
   logic                 settled;
   logic                 short_fire;
   logic [TIME_BITS-1:0] press_len;

   always_comb begin
      change_in   = (raw != prev_raw_ff) ? now_ms : change_ff;
      settled     = ((now_ms - change_in) >= TIME_BITS'(debounce_ms));
      down_in     = down_ff;
      stamp_next  = stamp_ff;
      waiting_mid = waiting_ff;
      if (settled && raw && !down_ff) begin
         down_in     = 1'b1;
         stamp_next  = now_ms;
         waiting_mid = 1'b1;
      end else if (settled && !raw && down_ff) begin
         down_in = 1'b0;
      end
      press_len  = now_ms - stamp_next;
      short_fire = 1'b0;
      if (!down_in && waiting_mid) begin
         short_fire  = (press_len >= TIME_BITS'(debounce_ms)) &&
                       (press_len < TIME_BITS'(short_max_ms));
         waiting_mid = 1'b0;
      end
      waiting_in = waiting_mid && !cancel;
   end

   assign status.down       = down_in;
   assign status.short_fire = short_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         down_ff     <= 1'b0;
         prev_raw_ff <= 1'b0;
         change_ff   <= '0;
         stamp_ff    <= '0;
         waiting_ff  <= 1'b0;
      end else if (advance) begin
         down_ff     <= down_in;
         prev_raw_ff <= raw;
         change_ff   <= change_in;
         stamp_ff    <= stamp_next;
         waiting_ff  <= waiting_in;
      end
   end

endmodule

// ===== sv/dbde_hold.sv =====
// ----------------------------------------------------------------------------
// Both-hold detector
// Times how long both buttons have been down, from the later press stamp,
// and reports one event per hold.
// ----------------------------------------------------------------------------
module dbde_hold
   import dbde_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   both_down,
   input  logic [TIME_BITS-1:0]   stamp_first,
   input  logic [TIME_BITS-1:0]   stamp_second,
   input  logic [TIME_BITS-1:0]   now_ms,
   input  logic [MS_BITS-1:0]     hold_both_ms,
   output logic                   hold_fire
);

   logic                 reported_ff, reported_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [TIME_BITS-1:0] later;
   logic [TIME_BITS-1:0] start_eff;

   always_comb begin
      later       = (stamp_first > stamp_second) ? stamp_first : stamp_second;
      start_eff   = (start_ff == '0) ? later : start_ff;
      hold_fire   = 1'b0;
      reported_in = reported_ff;
      start_in    = start_ff;
      if (both_down) begin
         if (!reported_ff) begin
            start_in = start_eff;
            if ((now_ms - start_eff) >= TIME_BITS'(hold_both_ms)) begin
               hold_fire   = 1'b1;
               reported_in = 1'b1;
            end
         end
      end else begin
         reported_in = 1'b0;
         start_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reported_ff <= 1'b0;
         start_ff    <= '0;
      end else if (advance) begin
         reported_ff <= reported_in;
         start_ff    <= start_in;
      end
   end

endmodule

// ===== sv/dual_button_debounce_events.sv =====
// ----------------------------------------------------------------------------
// Dual button debounce events
// Top level: input register, millisecond clock, two debouncers, the both-hold
// detector and the result register.
// ----------------------------------------------------------------------------
// Each input item is one poll tick with the raw pressed levels of two buttons
// and gives exactly one result item with the short-press and both-hold event
// flags and the debounced levels. An item is taken into an input register,
// processed combinationally and placed in the result register, and a new item
// is accepted every cycle as long as the result side keeps taking items. The
// configuration registers may only be written while no item is in flight.
module dual_button_debounce_events
   import dbde_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,  // raw_first, raw_second, zero pad
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,  // first_short, second_short,
                                                 // both_hold, first_down,
                                                 // second_down, zero pad
   input  logic                      csr_we,
   input  csr_index_type             csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [PERIOD_BITS-1:0] tick_period_ff;
   logic [MS_BITS-1:0]     debounce_ff;
   logic [MS_BITS-1:0]     short_max_ff;
   logic [MS_BITS-1:0]     hold_both_ff;

   logic                   in_valid_ff;
   logic [1:0]             in_raw_ff;
   logic                   out_valid_ff;
   logic [4:0]             out_data_ff, out_data_in;
   logic [TIME_BITS-1:0]   clock_ms_ff, clock_ms_in;
   logic                   advance;
   logic                   hold_fire;
   button_status_type      status_first, status_second;
   logic [TIME_BITS-1:0]   stamp_first, stamp_second;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_period_ff <= TICK_PERIOD_RESET;
         debounce_ff    <= DEBOUNCE_RESET;
         short_max_ff   <= SHORT_MAX_RESET;
         hold_both_ff   <= HOLD_BOTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TICK_PERIOD: tick_period_ff <= csr_wdata[PERIOD_BITS-1:0];
            CSR_DEBOUNCE:    debounce_ff    <= csr_wdata[MS_BITS-1:0];
            CSR_SHORT_MAX:   short_max_ff   <= csr_wdata[MS_BITS-1:0];
            CSR_HOLD_BOTH:   hold_both_ff   <= csr_wdata[MS_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_raw_ff <= req_tdata[1:0];
      end
   end

   assign clock_ms_in = clock_ms_ff + TIME_BITS'(tick_period_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ms_ff <= '0;
      end else if (advance) begin
         clock_ms_ff <= clock_ms_in;
      end
   end

   dbde_button #(
      .TIME_BITS (TIME_BITS)
   ) u_first (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .raw          (in_raw_ff[0]),
      .now_ms       (clock_ms_in),
      .debounce_ms  (debounce_ff),
      .short_max_ms (short_max_ff),
      .cancel       (hold_fire),
      .status       (status_first),
      .stamp_next   (stamp_first)
   );

   dbde_button #(
      .TIME_BITS (TIME_BITS)
   ) u_second (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .raw          (in_raw_ff[1]),
      .now_ms       (clock_ms_in),
      .debounce_ms  (debounce_ff),
      .short_max_ms (short_max_ff),
      .cancel       (hold_fire),
      .status       (status_second),
      .stamp_next   (stamp_second)
   );

   dbde_hold #(
      .TIME_BITS (TIME_BITS)
   ) u_hold (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .both_down    (status_first.down && status_second.down),
      .stamp_first  (stamp_first),
      .stamp_second (stamp_second),
      .now_ms       (clock_ms_in),
      .hold_both_ms (hold_both_ff),
      .hold_fire    (hold_fire)
   );

   assign out_data_in = {status_second.down, status_first.down, hold_fire,
                         status_second.short_fire, status_first.short_fire};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

// ===== dv/tb_dual_button_debounce_events.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dual button debounce events testbench
// Drives poll ticks with directed and random button levels through the stream input,
// predicts the debounced levels and the short-press and both-hold events for
// every tick, and checks each result item against the oldest prediction while
// both sides idle at random in some phases and the register settings change between phases.
// ----------------------------------------------------------------------------
module tb_dual_button_debounce_events;
   import dbde_pkg::*;

   typedef struct packed {
      logic second_down;
      logic first_down;
      logic both_hold;
      logic second_short;
      logic first_short;
   } button_events_type;

   class button_event_scoreboard;
      logic [PERIOD_BITS-1:0] tick_period;
      logic [MS_BITS-1:0] debounce_time;
      logic [MS_BITS-1:0] short_limit;
      logic [MS_BITS-1:0] hold_time;
      logic [31:0] now_ms;
      logic [31:0] hold_from;
      logic [31:0] change_at [2];
      logic [31:0] pressed_at [2];
      bit level_down [2];
      bit prev_level [2];
      bit short_armed [2];
      bit hold_done;
      button_events_type expected_events [$];
      int mismatches;

      function new();
         tick_period = TICK_PERIOD_RESET;
         debounce_time = DEBOUNCE_RESET;
         short_limit = SHORT_MAX_RESET;
         hold_time = HOLD_BOTH_RESET;
         now_ms = '0;
         hold_from = '0;
         hold_done = 1'b0;
         mismatches = 0;
         for (int k = 0; k < 2; k++) begin
            change_at[k] = '0;
            pressed_at[k] = '0;
            level_down[k] = 1'b0;
            prev_level[k] = 1'b0;
            short_armed[k] = 1'b0;
         end
      endfunction

      function void write_register(csr_index_type index,
                                   logic [CSR_DATA_BITS-1:0] value);
         case (index)
            CSR_TICK_PERIOD: tick_period = value[PERIOD_BITS-1:0];
            CSR_DEBOUNCE:    debounce_time = value;
            CSR_SHORT_MAX:   short_limit = value;
            CSR_HOLD_BOTH:   hold_time = value;
            default: ;
         endcase
      endfunction

      function void debounce_button(int k, bit raw);
         logic [31:0] steady;
         if (raw != prev_level[k]) begin
            prev_level[k] = raw;
            change_at[k] = now_ms;
         end
         steady = now_ms - change_at[k];
         if (steady >= {16'd0, debounce_time}) begin
            if (raw && !level_down[k]) begin
               level_down[k] = 1'b1;
               pressed_at[k] = now_ms;
               short_armed[k] = 1'b1;
            end else if (!raw && level_down[k]) begin
               level_down[k] = 1'b0;
            end
         end
      endfunction

      function bit release_event(int k);
         logic [31:0] held;
         release_event = 1'b0;
         if (!level_down[k] && short_armed[k]) begin
            held = now_ms - pressed_at[k];
            release_event = (held >= {16'd0, debounce_time}) &&
                            (held < {16'd0, short_limit});
            short_armed[k] = 1'b0;
         end
      endfunction

      function void note_tick(logic [7:0] data);
         button_events_type ev;
         logic [31:0] later;
         logic [31:0] both_for;
         now_ms = now_ms + {22'd0, tick_period};
         debounce_button(0, data[0]);
         debounce_button(1, data[1]);
         ev = '0;
         ev.first_short = release_event(0);
         ev.second_short = release_event(1);
         if (level_down[0] && level_down[1]) begin
            if (!hold_done) begin
               later = (pressed_at[0] > pressed_at[1]) ? pressed_at[0] : pressed_at[1];
               if (hold_from == '0) begin
                  hold_from = later;
               end
               both_for = now_ms - hold_from;
               if (both_for >= {16'd0, hold_time}) begin
                  ev.both_hold = 1'b1;
                  hold_done = 1'b1;
                  short_armed[0] = 1'b0;
                  short_armed[1] = 1'b0;
               end
            end
         end else begin
            hold_done = 1'b0;
            hold_from = '0;
         end
         ev.first_down = level_down[0];
         ev.second_down = level_down[1];
         expected_events.push_back(ev);
      endfunction

      function void report_mismatch(string what, button_events_type want,
                                    button_events_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $display({"%0t: %s: expected short %b/%b hold %b down %b/%b, ",
                      "got short %b/%b hold %b down %b/%b"},
                     $realtime, what, want.first_short, want.second_short, want.both_hold,
                     want.first_down, want.second_down, got.first_short, got.second_short,
                     got.both_hold, got.first_down, got.second_down);
         end
      endfunction

      function void check_result(logic [7:0] data);
         button_events_type want;
         button_events_type got;
         got = data[4:0];
         if (expected_events.size() == 0) begin
            want = 'x;
            report_mismatch("result with no tick pending", want, got);
         end else begin
            want = expected_events.pop_front();
            if (got.first_short !== want.first_short
                || got.second_short !== want.second_short
                || got.both_hold !== want.both_hold || got.first_down !== want.first_down
                || got.second_down !== want.second_down) begin
               report_mismatch("result mismatch", want, got);
            end
         end
      endfunction

      function int pending();
         return expected_events.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [7:0] rsp_tdata;
   logic csr_we;
   csr_index_type csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   button_event_scoreboard sb;
   bit sender_gaps;
   bit ready_gaps;
   bit long_stall_req;
   int stall_left;

   dual_button_debounce_events u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int gap_length();
      if ($urandom_range(0, 99) < 85) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      rsp_tready <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (long_stall_req) begin
            long_stall_req = 1'b0;
            stall_left = 299;
            rsp_tready <= 1'b0;
         end else if (!ready_gaps || $urandom_range(0, 99) < 70) begin
            rsp_tready <= 1'b1;
         end else begin
            stall_left = gap_length() - 1;
            rsp_tready <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         sb.note_tick(req_tdata);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata);
      end
   end

   task automatic send_tick(bit first, bit second);
      int gap;
      gap = (sender_gaps && $urandom_range(0, 99) >= 60) ? gap_length() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, second, first};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_drain(int settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type index, logic [CSR_DATA_BITS-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      sb.write_register(index, value);
      @(posedge clock);
   endtask

   task automatic set_config(logic [15:0] period, logic [15:0] debounce,
                             logic [15:0] short_max, logic [15:0] hold);
      write_reg(CSR_TICK_PERIOD, period);
      write_reg(CSR_DEBOUNCE, debounce);
      write_reg(CSR_SHORT_MAX, short_max);
      write_reg(CSR_HOLD_BOTH, hold);
      csr_we <= 1'b0;
   endtask

   // Runs of steady button levels, up to a span sized from the longest setting, with bounces and noise.
   task automatic random_phase(int count, bit pressure, bit midway_pause);
      int sent;
      int span;
      int run_len;
      int pick;
      int flip;
      int longest;
      bit first;
      bit second;
      longest = int'(sb.debounce_time);
      if (int'(sb.short_limit) > longest) longest = int'(sb.short_limit);
      if (int'(sb.hold_time) > longest) longest = int'(sb.hold_time);
      span = longest / ((sb.tick_period == 0) ? 1 : int'(sb.tick_period)) + 4;
      if (span > 40) span = 40;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            first = 1'($urandom_range(0, 1));
            second = 1'($urandom_range(0, 1));
            run_len = 1;
         end else begin
            first = (pick < 60);
            second = (pick >= 35 && pick < 85);
            run_len = $urandom_range(1, span);
         end
         repeat (run_len) begin
            flip = $urandom_range(0, 99);
            if (flip < 3) begin
               send_tick(~first, second);
            end else if (flip < 6) begin
               send_tick(first, ~second);
            end else begin
               send_tick(first, second);
            end
            sent++;
            if (pressure && sent == 20) long_stall_req = 1'b1;
            if (midway_pause && sent == 40) wait_drain(0);
         end
      end
      wait_drain(4);
   endtask

   initial begin
      sb = new();
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_TICK_PERIOD;
      csr_wdata <= '0;
      sender_gaps = 1'b0;
      ready_gaps = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Time held at zero: the press stamps and the hold start stay at zero.
      set_config(16'd0, 16'd0, 16'hFFFF, 16'd5);
      send_tick(1, 1);
      send_tick(1, 1);
      send_tick(1, 0);
      send_tick(0, 0);
      send_tick(0, 1);
      send_tick(0, 0);
      wait_drain(4);

      // Zero short limit and zero hold time.
      set_config(16'd10, 16'd0, 16'd0, 16'd0);
      send_tick(1, 0);
      send_tick(0, 0);
      send_tick(1, 1);
      send_tick(1, 1);
      send_tick(0, 1);
      send_tick(0, 0);
      send_tick(1, 1);
      wait_drain(4);

      // Largest settings; the period write carries bits above the field.
      set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_tick(1, 1);
      send_tick(1, 1);
      send_tick(1, 1);
      send_tick(0, 0);
      send_tick(0, 0);
      wait_drain(4);

      sender_gaps = 1'b1;
      set_config(16'd1, 16'd3, 16'd12, 16'd20);
      random_phase(80, 1'b1, 1'b0);

      sender_gaps = 1'b0;
      ready_gaps = 1'b0;
      set_config(16'd5, 16'($urandom_range(0, 30)), 16'($urandom_range(20, 120)),
                 16'($urandom_range(0, 150)));
      random_phase(60, 1'b0, 1'b1);

      sender_gaps = 1'b1;
      ready_gaps = 1'b1;
      set_config(16'd20, 16'd40, 16'd300, 16'd500);
      random_phase(80, 1'b0, 1'b0);

      set_config(16'hFFFF, 16'd2000, 16'hFFFF, 16'd10000);
      random_phase(60, 1'b0, 1'b0);

      set_config(16'd3, 16'd0, 16'd0, 16'd9);
      random_phase(50, 1'b0, 1'b0);

      set_config(16'd0, 16'd0, 16'd1, 16'd0);
      random_phase(30, 1'b0, 1'b0);

      set_config(16'(TICK_PERIOD_RESET), DEBOUNCE_RESET, SHORT_MAX_RESET,
                 HOLD_BOTH_RESET);
      random_phase(40, 1'b0, 1'b0);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/dbde_pkg.sv
sv/dbde_button.sv
sv/dbde_hold.sv
sv/dual_button_debounce_events.sv
dv/tb_dual_button_debounce_events.sv
